// ===== rtl/usrt_pkg.sv =====
// usrt_pkg: shared constants, codes and field widths of the user slot resend table.
// No dependencies; used by the channel interfaces and the top level.
package usrt_pkg;

   localparam int USERS_DEF       = 64;
   localparam int SLOTS_DEF       = 4;
   localparam int MAX_RESULTS     = 4;
   localparam int KW              = $clog2(MAX_RESULTS + 1);
   localparam logic [15:0] INTERVAL_RST = 16'd30;

   typedef enum logic [2:0] {
      OP_ALLOC  = 3'd0,
      OP_FREE   = 3'd1,
      OP_PUSH   = 3'd2,
      OP_BCAST  = 3'd3,
      OP_POLL   = 3'd4,
      OP_ACK    = 3'd5,
      OP_CANCEL = 3'd6,
      OP_NOP    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_BAD  = 2'd1,
      ST_NONE = 2'd2
   } status_type;

endpackage

// ===== rtl/usrt_if.sv =====
// usrt_if: valid/ready channel interfaces for request and response words.
// Depends on usrt_pkg for the operation and status codes.
interface usrt_req_if;
   import usrt_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [7:0]  user_id;
   logic [30:0] msg_id;
   logic [31:0] now;
   logic [15:0] rate;
   modport source (output valid, opcode, user_id, msg_id, now, rate, input ready);
   modport sink   (input valid, opcode, user_id, msg_id, now, rate, output ready);
endinterface

interface usrt_rsp_if;
   import usrt_pkg::*;
   logic        valid;
   logic        ready;
   status_type  status;
   logic [5:0]  out_user_id;
   logic [30:0] out_msg_id;
   logic [6:0]  free_count;
   logic        last;
   modport source (output valid, status, out_user_id, out_msg_id, free_count, last,
                   input ready);
   modport sink   (input valid, status, out_user_id, out_msg_id, free_count, last,
                   output ready);
endinterface

// ===== rtl/user_slot_resend_table.sv =====
// user_slot_resend_table: per-user message slot table with resend timing.
// Depends on usrt_pkg and the channel interfaces in usrt_if.sv.
//
//   channel | dir | fields                                         | accept
//   req     | in  | opcode user_id msg_id now rate                 | valid & ready
//   rsp     | out | status out_user_id out_msg_id free_count last  | valid & ready
//   csr     | in  | csr_wdata (resend_interval)                    | csr_we
//
// One word at a time. Free, push, bad user and no-op go straight to the final
// word; alloc walks the user bits one per cycle, broadcast writes one user per cycle.
// Ack and poll walk one user's slots, a registered memory read and then a compare
// per valid slot; cancel does that for every active user.
// Synchronous reset clears the user and slot valid bits; stamp and message
// memories hold no reset. A stalled response holds the walk, not the table.
module user_slot_resend_table
   #(parameter int USERS = usrt_pkg::USERS_DEF,
     parameter int SLOTS = usrt_pkg::SLOTS_DEF)
   (input  logic               clock,
    input  logic               reset,
    usrt_req_if.sink           req,
    usrt_rsp_if.source         rsp,
    input  logic               csr_we,
    input  logic [15:0]        csr_wdata);

   import usrt_pkg::*;

   localparam int UW    = (USERS > 1) ? $clog2(USERS) : 1;
   localparam int UCW   = $clog2(USERS) + 1;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCW   = $clog2(SLOTS) + 1;
   localparam int DEPTH = USERS * SLOTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW    = $clog2(USERS + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_ALLOC = 7'b0000010,
      S_BCAST = 7'b0000100,
      S_UWALK = 7'b0001000,
      S_SRD   = 7'b0010000,
      S_SEV   = 7'b0100000,
      S_FIN   = 7'b1000000
   } state_type;

   function automatic logic [AW-1:0] slot_addr(input logic [UW-1:0] u,
                                                input logic [SW-1:0] s);
      slot_addr = AW'(AW'(u) * AW'(SLOTS) + AW'(s));
   endfunction

   // control state
   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [UCW-1:0]     ucnt_ff, ucnt_in;
   logic [SCW-1:0]     scnt_ff, scnt_in;
   logic [KW-1:0]      k_ff, k_in;
   logic               pend_ff, pend_in;
   logic [USERS-1:0]   active_ff, active_in;
   logic [DEPTH-1:0]   valid_ff, valid_in;
   logic [FW-1:0]      free_ff, free_in;
   logic [15:0]        interval_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   // payload
   logic [30:0]        msg_ff, msg_in;
   logic [31:0]        now_ff, now_in;
   logic [15:0]        rate_ff, rate_in;
   logic [31:0]        bstamp_ff, bstamp_in;
   logic [UCW-1:0]     bcnt_ff, bcnt_in;
   logic [30:0]        pend_msg_ff, pend_msg_in;
   status_type         fin_status_ff, fin_status_in;
   logic [5:0]         fin_uid_ff, fin_uid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [5:0]         rsp_uid_ff, rsp_uid_in;
   logic [30:0]        rsp_msg_ff, rsp_msg_in;
   logic [6:0]         rsp_free_ff, rsp_free_in;
   logic               rsp_last_ff, rsp_last_in;

   // memories
   logic [31:0]        stamp_mem [DEPTH];
   logic [30:0]        msg_mem [DEPTH];
   logic [31:0]        rd_stamp_ff;
   logic [30:0]        rd_msg_ff;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               stamp_we, msg_we;
   logic [31:0]        stamp_wd;
   logic [30:0]        msg_wd;

   // shared slot store unit
   logic               st_en;
   logic [UW-1:0]      st_user;
   logic [SW-1:0]      st_slot;
   logic [30:0]        st_msg;
   logic [31:0]        st_stamp;

   logic               out_free;
   logic [UW-1:0]      cur_user;
   logic [AW-1:0]      cur_addr;
   logic               req_ok;
   logic [UW-1:0]      req_user;
   logic               due;
   logic [UCW-1:0]     bcnt_next;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign cur_user = ucnt_ff[UW-1:0];
   assign cur_addr = slot_addr(cur_user, scnt_ff[SW-1:0]);
   assign rd_addr  = cur_addr;
   assign req_ok   = {1'b0, req.user_id} < 9'(USERS);
   assign req_user = req.user_id[UW-1:0];
   assign due      = {1'b0, now_ff} >= ({1'b0, rd_stamp_ff} + 33'(interval_ff));
   assign bcnt_next = bcnt_ff + UCW'(active_ff[cur_user]);
   assign req.ready = (state_ff == S_IDLE);

   // find the first empty slot of the chosen user, slot 0 when all are full
   always_comb begin
      logic found;
      found   = 1'b0;
      st_slot = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (!found && !valid_ff[slot_addr(st_user, SW'(s))]) begin
            st_slot = SW'(s);
            found   = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ucnt_in       = ucnt_ff;
      scnt_in       = scnt_ff;
      k_in          = k_ff;
      pend_in       = pend_ff;
      active_in     = active_ff;
      valid_in      = valid_ff;
      free_in       = free_ff;
      msg_in        = msg_ff;
      now_in        = now_ff;
      rate_in       = rate_ff;
      bstamp_in     = bstamp_ff;
      bcnt_in       = bcnt_ff;
      pend_msg_in   = pend_msg_ff;
      fin_status_in = fin_status_ff;
      fin_uid_in    = fin_uid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_uid_in    = rsp_uid_ff;
      rsp_msg_in    = rsp_msg_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_last_in   = rsp_last_ff;
      st_en         = 1'b0;
      st_user       = cur_user;
      st_msg        = msg_ff;
      st_stamp      = bstamp_ff;
      stamp_we      = 1'b0;
      msg_we        = 1'b0;
      stamp_wd      = now_ff;
      msg_wd        = msg_ff;
      wr_addr       = cur_addr;

      // drop the response word once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            st_user = req_user;
            st_msg  = req.msg_id;
            st_stamp = req.now;
            if (req.valid) begin
               op_in         = op_type'(req.opcode);
               msg_in        = req.msg_id;
               now_in        = req.now;
               rate_in       = req.rate;
               fin_status_in = ST_OK;
               fin_uid_in    = '0;
               pend_msg_in   = '0;
               pend_in       = 1'b0;
               k_in          = '0;
               scnt_in       = '0;
               ucnt_in       = UCW'(req_user);
               state_in      = S_FIN;
               case (op_type'(req.opcode))
                  OP_ALLOC: begin
                     ucnt_in  = '0;
                     state_in = S_ALLOC;
                  end
                  OP_FREE: begin
                     if (!req_ok) begin
                        fin_status_in = ST_BAD;
                     end else begin
                        if (active_ff[req_user]) begin
                           active_in[req_user] = 1'b0;
                           free_in = free_ff + FW'(1);
                        end
                        for (int s = 0; s < SLOTS; s++) begin
                           valid_in[slot_addr(req_user, SW'(s))] = 1'b0;
                        end
                     end
                  end
                  OP_PUSH: begin
                     if (!req_ok) begin
                        fin_status_in = ST_BAD;
                     end else if (active_ff[req_user]) begin
                        st_en = 1'b1;
                     end
                  end
                  OP_BCAST: begin
                     ucnt_in   = '0;
                     bcnt_in   = '0;
                     bstamp_in = (req.now > {16'b0, interval_ff}) ?
                                 req.now - {16'b0, interval_ff} : '0;
                     state_in  = S_BCAST;
                  end
                  OP_POLL, OP_ACK: begin
                     if (!req_ok) begin
                        fin_status_in = ST_BAD;
                     end else if (!active_ff[req_user]) begin
                        fin_status_in = (op_type'(req.opcode) == OP_POLL) ? ST_NONE : ST_OK;
                     end else begin
                        state_in = S_SRD;
                     end
                  end
                  OP_CANCEL: begin
                     ucnt_in  = '0;
                     state_in = S_UWALK;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         // walk for the lowest free id
         S_ALLOC: begin
            if (ucnt_ff == UCW'(USERS)) begin
               fin_status_in = ST_BAD;
               state_in      = S_FIN;
            end else if (!active_ff[cur_user]) begin
               active_in[cur_user] = 1'b1;
               free_in    = free_ff - FW'(1);
               fin_uid_in = 6'(9'(ucnt_ff));
               state_in   = S_FIN;
            end else begin
               ucnt_in = ucnt_ff + UCW'(1);
            end
         end

         // visit one user per cycle, storing into active ones; advance the stamp every rate active users
         S_BCAST: begin
            if (ucnt_ff == UCW'(USERS)) begin
               state_in = S_FIN;
            end else begin
               st_en   = active_ff[cur_user];
               ucnt_in = ucnt_ff + UCW'(1);
               if (16'(bcnt_next) >= rate_ff) begin
                  bcnt_in = '0;
                  if (bstamp_ff != '1) begin
                     bstamp_in = bstamp_ff + 32'd1;
                  end
               end else begin
                  bcnt_in = bcnt_next;
               end
            end
         end

         // skip inactive users during a cancel
         S_UWALK: begin
            if (ucnt_ff == UCW'(USERS)) begin
               state_in = S_FIN;
            end else if (active_ff[cur_user]) begin
               scnt_in  = '0;
               state_in = S_SRD;
            end else begin
               ucnt_in = ucnt_ff + UCW'(1);
            end
         end

         // issue a slot read, or close out the user
         S_SRD: begin
            if (scnt_ff == SCW'(SLOTS) ||
                (op_ff == OP_POLL && k_ff == KW'(MAX_RESULTS))) begin
               if (op_ff == OP_CANCEL) begin
                  ucnt_in  = ucnt_ff + UCW'(1);
                  state_in = S_UWALK;
               end else begin
                  if (op_ff == OP_POLL) begin
                     fin_status_in = pend_ff ? ST_OK : ST_NONE;
                  end
                  state_in = S_FIN;
               end
            end else if (valid_ff[cur_addr]) begin
               state_in = S_SEV;
            end else begin
               scnt_in = scnt_ff + SCW'(1);
            end
         end

         // compare the read slot
         S_SEV: begin
            if (op_ff == OP_POLL) begin
               if (!due) begin
                  scnt_in  = scnt_ff + SCW'(1);
                  state_in = S_SRD;
               end else if (!pend_ff || out_free) begin
                  if (pend_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_uid_in    = '0;
                     rsp_msg_in    = pend_msg_ff;
                     rsp_free_in   = 7'(9'(free_ff));
                     rsp_last_in   = 1'b0;
                  end
                  pend_in     = 1'b1;
                  pend_msg_in = rd_msg_ff;
                  k_in        = k_ff + KW'(1);
                  stamp_we    = 1'b1;
                  stamp_wd    = now_ff;
                  scnt_in     = scnt_ff + SCW'(1);
                  state_in    = S_SRD;
               end
            end else begin
               if (rd_msg_ff == msg_ff) begin
                  valid_in[cur_addr] = 1'b0;
                  scnt_in = SCW'(SLOTS);
               end else begin
                  scnt_in = scnt_ff + SCW'(1);
               end
               state_in = S_SRD;
            end
         end

         // hand out the final word
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fin_status_ff;
               rsp_uid_in    = fin_uid_ff;
               rsp_msg_in    = (fin_status_ff == ST_OK) ? pend_msg_ff : '0;
               rsp_free_in   = 7'(9'(free_ff));
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // shared store: first empty slot, or slot 0
      if (st_en) begin
         wr_addr  = slot_addr(st_user, st_slot);
         valid_in[slot_addr(st_user, st_slot)] = 1'b1;
         stamp_we = 1'b1;
         msg_we   = 1'b1;
         stamp_wd = st_stamp;
         msg_wd   = st_msg;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_NOP;
         ucnt_ff      <= '0;
         scnt_ff      <= '0;
         k_ff         <= '0;
         pend_ff      <= 1'b0;
         active_ff    <= '0;
         valid_ff     <= '0;
         free_ff      <= FW'(USERS);
         interval_ff  <= INTERVAL_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         ucnt_ff      <= ucnt_in;
         scnt_ff      <= scnt_in;
         k_ff         <= k_in;
         pend_ff      <= pend_in;
         active_ff    <= active_in;
         valid_ff     <= valid_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            interval_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      msg_ff        <= msg_in;
      now_ff        <= now_in;
      rate_ff       <= rate_in;
      bstamp_ff     <= bstamp_in;
      bcnt_ff       <= bcnt_in;
      pend_msg_ff   <= pend_msg_in;
      fin_status_ff <= fin_status_in;
      fin_uid_ff    <= fin_uid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_uid_ff    <= rsp_uid_in;
      rsp_msg_ff    <= rsp_msg_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // slot memories: one write, one registered read
   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem[wr_addr] <= stamp_wd;
      end
      if (msg_we) begin
         msg_mem[wr_addr] <= msg_wd;
      end
      rd_stamp_ff <= stamp_mem[rd_addr];
      rd_msg_ff   <= msg_mem[rd_addr];
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.out_user_id = rsp_uid_ff;
   assign rsp.out_msg_id  = rsp_msg_ff;
   assign rsp.free_count  = rsp_free_ff;
   assign rsp.last        = rsp_last_ff;

endmodule

// ===== bench/usrt_tb_pkg.sv =====
// usrt_tb_pkg: word types shared by the checker and the stimulus of the testbench.
// Depends on usrt_pkg for the operation and status codes.
package usrt_tb_pkg;
   import usrt_pkg::*;

   typedef struct packed {
      op_type      opcode;
      logic [7:0]  user_id;
      logic [30:0] msg_id;
      logic [31:0] now;
      logic [15:0] rate;
   } req_word_t;

   typedef struct packed {
      status_type  status;
      logic [5:0]  out_user_id;
      logic [30:0] out_msg_id;
      logic [6:0]  free_count;
      logic        last;
   } rsp_word_t;

endpackage

// ===== bench/usrt_table_checker.sv =====
// usrt_table_checker: predicts the response words of the resend table and compares them.
// Depends on usrt_pkg, usrt_tb_pkg and the channel interfaces in rtl/usrt_if.sv.
module usrt_table_checker
   import usrt_pkg::*;
   import usrt_tb_pkg::*;
   (input  logic        clock,
    input  logic        reset,
    usrt_req_if         req,
    usrt_rsp_if         rsp,
    input  logic        csr_we,
    input  logic [15:0] csr_wdata,
    output int          fail_count,
    output int          pending_words);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int USERS = USERS_DEF;
   localparam int SLOTS = SLOTS_DEF;

   // shadow copy of the table
   logic [15:0] interval;
   logic        active[USERS];
   logic        slot_ok[USERS*SLOTS];
   logic [31:0] slot_time[USERS*SLOTS];
   logic [30:0] slot_msg[USERS*SLOTS];
   logic [6:0]  free_left;

   rsp_word_t expected_rsp[$];

   function automatic rsp_word_t mk(status_type st, logic [5:0] uid, logic [30:0] msg,
                                    logic lst);
      rsp_word_t w;
      w.status = st;
      w.out_user_id = uid;
      w.out_msg_id = msg;
      w.free_count = free_left;
      w.last = lst;
      return w;
   endfunction

   function automatic void place_msg(int u, logic [30:0] msg, logic [31:0] stamp);
      int s;
      s = 0;
      while (s < SLOTS && slot_ok[u*SLOTS+s]) s++;
      if (s == SLOTS) s = 0;
      slot_ok[u*SLOTS+s] = 1'b1;
      slot_time[u*SLOTS+s] = stamp;
      slot_msg[u*SLOTS+s] = msg;
   endfunction

   function automatic void drop_match(int u, logic [30:0] msg);
      for (int s = 0; s < SLOTS; s++) begin
         if (slot_ok[u*SLOTS+s] && slot_msg[u*SLOTS+s] == msg) begin
            slot_ok[u*SLOTS+s] = 1'b0;
            return;
         end
      end
   endfunction

   // apply one request word to the shadow table and queue its responses
   function automatic void predict_table(req_word_t w);
      logic bad;
      int   k;
      logic [31:0] stamp;
      int   cnt;
      bad = w.user_id >= USERS;
      case (w.opcode)
         OP_ALLOC: begin
            for (int u = 0; u < USERS; u++) begin
               if (!active[u]) begin
                  active[u] = 1'b1;
                  free_left--;
                  expected_rsp.push_back(mk(ST_OK, 6'(u), '0, 1'b1));
                  return;
               end
            end
            expected_rsp.push_back(mk(ST_BAD, '0, '0, 1'b1));
         end
         OP_FREE, OP_PUSH, OP_ACK: begin
            if (bad) begin
               expected_rsp.push_back(mk(ST_BAD, '0, '0, 1'b1));
               return;
            end
            if (w.opcode == OP_FREE) begin
               if (active[w.user_id]) begin
                  active[w.user_id] = 1'b0;
                  free_left++;
               end
               for (int s = 0; s < SLOTS; s++) slot_ok[w.user_id*SLOTS+s] = 1'b0;
            end else if (active[w.user_id]) begin
               if (w.opcode == OP_PUSH) place_msg(w.user_id, w.msg_id, w.now);
               else drop_match(w.user_id, w.msg_id);
            end
            expected_rsp.push_back(mk(ST_OK, '0, '0, 1'b1));
         end
         OP_BCAST: begin
            stamp = (w.now > interval) ? w.now - interval : '0;
            cnt = 0;
            for (int u = 0; u < USERS; u++) begin
               if (active[u]) begin
                  place_msg(u, w.msg_id, stamp);
                  cnt++;
               end
               if (cnt >= w.rate) begin
                  cnt = 0;
                  if (stamp != 32'hFFFF_FFFF) stamp++;
               end
            end
            expected_rsp.push_back(mk(ST_OK, '0, '0, 1'b1));
         end
         OP_POLL: begin
            if (bad) begin
               expected_rsp.push_back(mk(ST_BAD, '0, '0, 1'b1));
               return;
            end
            k = 0;
            if (active[w.user_id]) begin
               for (int s = 0; s < SLOTS && k < MAX_RESULTS; s++) begin
                  int i;
                  i = w.user_id*SLOTS + s;
                  if (slot_ok[i] && {1'b0, w.now} >= {1'b0, slot_time[i]} + interval) begin
                     slot_time[i] = w.now;
                     expected_rsp.push_back(mk(ST_OK, '0, slot_msg[i], 1'b0));
                     k++;
                  end
               end
            end
            if (k == 0) expected_rsp.push_back(mk(ST_NONE, '0, '0, 1'b1));
            else expected_rsp[$].last = 1'b1;
         end
         OP_CANCEL: begin
            for (int u = 0; u < USERS; u++) if (active[u]) drop_match(u, w.msg_id);
            expected_rsp.push_back(mk(ST_OK, '0, '0, 1'b1));
         end
         default: expected_rsp.push_back(mk(ST_OK, '0, '0, 1'b1));
      endcase
   endfunction

   // watch both channels at each rising edge
   always @(posedge clock) begin
      req_word_t rq;
      rsp_word_t got, exp_w;
      if (reset) begin
         interval <= INTERVAL_RST;
         for (int i = 0; i < USERS; i++) active[i] = 1'b0;
         for (int i = 0; i < USERS*SLOTS; i++) slot_ok[i] = 1'b0;
         free_left = 7'(USERS);
         expected_rsp.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) interval <= csr_wdata;
         if (rsp.valid && rsp.ready) begin
            got = {rsp.status, rsp.out_user_id, rsp.out_msg_id, rsp.free_count, rsp.last};
            if (expected_rsp.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected response word %h", got);
            end else begin
               exp_w = expected_rsp.pop_front();
               if (got !== exp_w) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("response mismatch: expected st=%0d uid=%0d msg=%h ",
                              "free=%0d last=%b, got st=%0d uid=%0d msg=%h ",
                              "free=%0d last=%b",
                              exp_w.status, exp_w.out_user_id, exp_w.out_msg_id,
                              exp_w.free_count, exp_w.last, got.status, got.out_user_id,
                              got.out_msg_id, got.free_count, got.last);
               end
            end
         end
         if (req.valid && req.ready) begin
            rq.opcode = op_type'(req.opcode);
            rq.user_id = req.user_id;
            rq.msg_id = req.msg_id;
            rq.now = req.now;
            rq.rate = req.rate;
            predict_table(rq);
         end
      end
      pending_words = expected_rsp.size();
   end

endmodule

// ===== bench/user_slot_resend_table_tb.sv =====
// user_slot_resend_table_tb: drives request words and interval writes into the table.
// Depends on usrt_pkg, usrt_tb_pkg, rtl/usrt_if.sv and usrt_table_checker.
module user_slot_resend_table_tb;
   import usrt_pkg::*;
   import usrt_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;
   int          fail_count;
   int          pending_words;

   usrt_req_if req ();
   usrt_rsp_if rsp ();

   user_slot_resend_table i_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata));

   usrt_table_checker i_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_words(pending_words));

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // end the run as failed if the table hangs
   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // drive one request word and hold it until accepted; valid stays high afterwards
   task automatic send_word(op_type op, logic [7:0] uid, logic [30:0] msg,
                            logic [31:0] tnow, logic [15:0] rt);
      int g;
      g = gap_len();
      @(negedge clock);
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.opcode <= op;
      req.user_id <= uid;
      req.msg_id <= msg;
      req.now <= tnow;
      req.rate <= rt;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // drop valid after the last accepted word
   task automatic idle_req();
      @(negedge clock);
      req.valid <= 1'b0;
   endtask

   // let the table drain, then write the interval
   task automatic set_interval(logic [15:0] v);
      idle_req();
      while (pending_words != 0) @(negedge clock);
      repeat (150) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // random receiver stalls
   initial begin
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         if ($urandom_range(0, 3) == 0) begin
            rsp.ready <= 1'b0;
            repeat (gap_len() + 1) @(negedge clock);
         end
      end
   end

   // one random word, mostly to live ids and with times near the stamps
   task automatic random_word(logic [31:0] base);
      op_type      op;
      logic [7:0]  uid;
      logic [30:0] msg;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 10) op = OP_ALLOC;
      else if (r < 16) op = OP_FREE;
      else if (r < 40) op = OP_PUSH;
      else if (r < 48) op = OP_BCAST;
      else if (r < 72) op = OP_POLL;
      else if (r < 86) op = OP_ACK;
      else if (r < 92) op = OP_CANCEL;
      else if (r < 95) op = OP_NOP;
      else op = op_type'($urandom_range(0, 7));
      uid = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
      msg = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 7));
      send_word(op, uid, msg, base + $urandom_range(0, 80),
                ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)));
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.opcode = OP_NOP;
      req.user_id = '0;
      req.msg_id = '0;
      req.now = '0;
      req.rate = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, extremes, overflow of slots
      send_word(OP_POLL, 8'd0, '0, '0, 16'd1);
      send_word(OP_ALLOC, 8'hFF, '0, '0, 16'd1);
      send_word(OP_ALLOC, 8'd0, '0, '0, 16'd1);
      send_word(OP_PUSH, 8'd0, 31'h7FFF_FFFF, 32'd0, 16'd1);
      for (int i = 0; i < 4; i++) send_word(OP_PUSH, 8'd1, 31'(i + 1), 32'd5, 16'd1);
      send_word(OP_PUSH, 8'd1, 31'd9, 32'd6, 16'd1);
      send_word(OP_POLL, 8'd1, '0, 32'd36, 16'd1);
      send_word(OP_POLL, 8'd1, '0, 32'd40, 16'd1);
      send_word(OP_ACK, 8'd1, 31'd3, 32'd0, 16'd1);
      send_word(OP_ACK, 8'd63, 31'd3, 32'd0, 16'd1);
      send_word(OP_PUSH, 8'd64, '0, '0, 16'd1);
      send_word(OP_POLL, 8'd255, '0, 32'hFFFF_FFFF, 16'd1);
      send_word(OP_FREE, 8'd200, '0, '0, 16'd1);
      send_word(OP_BCAST, 8'd0, 31'd77, 32'hFFFF_FFFF, 16'd0);
      send_word(OP_BCAST, 8'd0, 31'd78, 32'd10, 16'hFFFF);
      send_word(OP_POLL, 8'd0, '0, 32'hFFFF_FFFF, 16'd1);
      send_word(OP_CANCEL, 8'hFF, 31'd77, '0, 16'd1);
      send_word(OP_FREE, 8'd1, '0, '0, 16'd1);
      send_word(OP_FREE, 8'd1, '0, '0, 16'd1);
      send_word(OP_NOP, 8'hAA, 31'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
      for (int i = 0; i < 65; i++) send_word(OP_ALLOC, '0, '0, '0, 16'd1);

      // random phases over several intervals, extremes included
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_interval(16'd0);
            1: set_interval(16'hFFFF);
            2: set_interval(16'd7);
            default: set_interval(16'($urandom_range(1, 60)));
         endcase
         if (ph == 1) begin
            for (int u = 10; u < 64; u++) send_word(OP_FREE, 8'(u), '0, '0, 16'd1);
         end
         for (int i = 0; i < 35; i++) begin
            random_word(ph == 1 ? 32'hFFFF_FFA0 : 32'(i * 10));
            if (i == 17) begin
               idle_req();
               while (pending_words != 0) @(negedge clock);
            end
         end
      end

      idle_req();
      while (pending_words != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== user_slot_resend_table.f =====
rtl/usrt_pkg.sv
rtl/usrt_if.sv
rtl/user_slot_resend_table.sv
bench/usrt_tb_pkg.sv
bench/usrt_table_checker.sv
bench/user_slot_resend_table_tb.sv
